// ===== src/tlbpt_pkg.sv =====
package tlbpt_pkg;

    localparam int TLB_ENTRIES_DEF = 16;
    localparam int PAGE_COUNT_DEF  = 256;
    localparam int FRAME_MAX_DEF   = 256;
    localparam int OFFSET_BITS_DEF = 8;

    localparam int ADDR_W       = 16;
    localparam int CFG_W        = 9;
    localparam int EV_PAGE_W    = 8;
    localparam logic [CFG_W-1:0] FRAME_COUNT_RST = 9'd128;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;     // latch input item and compute tlb lookup
        logic rd_victim;   // issue reads for victim page
        logic rd_neigh;    // read neighbor links
        logic commit;      // write back state and load result
    } tlbpt_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic need_evict;
    } tlbpt_sts_t;

endpackage

// ===== src/tlbpt_if.sv =====
interface tlbpt_if #(
    parameter int W = 16
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/tlbpt_ram.sv =====
module tlbpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== src/tlbpt_ctrl.sv =====
module tlbpt_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  tlbpt_pkg::tlbpt_sts_t sts,
    output tlbpt_pkg::tlbpt_cmd_t cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_LOOK, S_VICT, S_NEIGH, S_COMMIT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_LOOK;
                end
            end
            S_LOOK:
            begin
                // page reads in flight
                state_next = S_VICT;
            end
            S_VICT:
            begin
                cmd.rd_victim = 1'b1;
                // victim links only matter when a page gets evicted
                state_next    = sts.need_evict ? S_NEIGH : S_COMMIT;
            end
            S_NEIGH:
            begin
                cmd.rd_neigh = 1'b1;
                state_next   = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd.commit     = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

// ===== src/tlbpt_dp.sv =====
module tlbpt_dp #(
    parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF,
    parameter int PAGE_COUNT  = tlbpt_pkg::PAGE_COUNT_DEF,
    parameter int FRAME_MAX   = tlbpt_pkg::FRAME_MAX_DEF,
    parameter int OFFSET_BITS = tlbpt_pkg::OFFSET_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tlbpt_pkg::tlbpt_cmd_t             cmd,
    output tlbpt_pkg::tlbpt_sts_t             sts,
    input  logic [tlbpt_pkg::ADDR_W-1:0]      addr_in,
    input  logic                              cfg_we,
    input  logic [tlbpt_pkg::CFG_W-1:0]       cfg_data,
    output logic [tlbpt_pkg::ADDR_W-1:0]      phys_out,
    output logic                              hit_out,
    output logic                              fault_out,
    output logic                              ev_out,
    output logic [tlbpt_pkg::EV_PAGE_W-1:0]   ev_page_out
);
    localparam int PW = $clog2(PAGE_COUNT);
    localparam int FW = $clog2(FRAME_MAX);
    localparam int TW = $clog2(TLB_ENTRIES);
    localparam int UW = FW + 1;
    localparam int CW = tlbpt_pkg::CFG_W;
    localparam int AW = tlbpt_pkg::ADDR_W;
    localparam int EW = tlbpt_pkg::EV_PAGE_W;

    // configuration
    logic [CW-1:0] fcount_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fcount_reg <= tlbpt_pkg::FRAME_COUNT_RST;
        end
        else if (cfg_we)
        begin
            fcount_reg <= cfg_data;
        end
    end

    logic [UW-1:0] limit;
    always_comb
    begin
        if (fcount_reg == '0)
        begin
            limit = UW'(1);
        end
        else if (32'(fcount_reg) > FRAME_MAX)
        begin
            limit = UW'(FRAME_MAX);
        end
        else
        begin
            limit = UW'(fcount_reg);
        end
    end

    // item registers
    logic [PW-1:0]          page_reg;
    logic [OFFSET_BITS-1:0] off_reg;
    logic                   hit_reg;
    logic [FW-1:0]          tframe_reg;

    // tlb in flops
    logic [PW-1:0]          tlb_page_reg  [TLB_ENTRIES];
    logic [FW-1:0]          tlb_frame_reg [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] tlb_valid_reg, tlb_valid_next;
    logic [TW-1:0]          tlb_ptr_reg;

    logic [PAGE_COUNT-1:0]  pvalid_reg, pvalid_next;
    logic [UW-1:0]          used_reg;
    logic [PW-1:0]          oldest_reg, newest_reg;

    // page number wraps at the table size
    logic [PW-1:0] cap_page;
    assign cap_page = PW'(addr_in[AW-1:OFFSET_BITS]);

    logic          look_hit;
    logic [FW-1:0] look_frame;
    always_comb
    begin
        look_hit   = 1'b0;
        look_frame = '0;
        for (int k = TLB_ENTRIES - 1; k >= 0; k--)
        begin
            if (tlb_valid_reg[k] && tlb_page_reg[k] == cap_page)
            begin
                look_hit   = 1'b1;
                look_frame = tlb_frame_reg[k];
            end
        end
    end

    // memories: page_frame, lru_next, lru_prev
    logic          pf_we;
    logic [PW-1:0] pf_waddr, pf_raddr;
    logic [FW-1:0] pf_wdata, pf_rdata;
    logic          nx_we, pv_we;
    logic [PW-1:0] nx_waddr, nx_raddr, nx_wdata, nx_rdata;
    logic [PW-1:0] pv_waddr, pv_raddr, pv_wdata, pv_rdata;

    tlbpt_ram #(.WIDTH(FW), .DEPTH(PAGE_COUNT)) u_pf (
        .clk(clk), .we(pf_we), .waddr(pf_waddr), .wdata(pf_wdata),
        .raddr(pf_raddr), .rdata(pf_rdata)
    );
    tlbpt_ram #(.WIDTH(PW), .DEPTH(PAGE_COUNT)) u_nx (
        .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
        .raddr(nx_raddr), .rdata(nx_rdata)
    );
    tlbpt_ram #(.WIDTH(PW), .DEPTH(PAGE_COUNT)) u_pv (
        .clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
        .raddr(pv_raddr), .rdata(pv_rdata)
    );

    // captured link data
    logic [PW-1:0] p_next_reg, p_prev_reg;   // links of page
    logic [PW-1:0] v_next_reg;               // next of victim
    logic [FW-1:0] p_frame_reg, v_frame_reg;

    logic fault, evict, touch;
    assign fault = !hit_reg && !pvalid_reg[page_reg];
    assign evict = fault && (used_reg >= limit);
    // moved page must be unlinked (hit or table hit, not newest)
    assign touch = !fault && (page_reg != newest_reg);

    assign sts.need_evict = evict;

    // read address sequencing
    always_comb
    begin
        pf_raddr = page_reg;
        nx_raddr = page_reg;
        pv_raddr = page_reg;
        if (cmd.rd_victim)
        begin
            pf_raddr = oldest_reg;
            nx_raddr = oldest_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            page_reg   <= cap_page;
            off_reg    <= addr_in[OFFSET_BITS-1:0];
            hit_reg    <= look_hit;
            tframe_reg <= look_frame;
        end
        if (cmd.rd_victim)
        begin
            p_frame_reg <= pf_rdata;
            p_next_reg  <= nx_rdata;
            p_prev_reg  <= pv_rdata;
        end
        if (cmd.rd_neigh)
        begin
            v_frame_reg <= pf_rdata;
            v_next_reg  <= nx_rdata;
        end
    end

    // commit: resolve frame and lru list changes
    logic [FW-1:0] frame;
    logic [PW-1:0] victim;
    logic [PW-1:0] oldest_next, newest_next;
    logic          empty_app;
    always_comb
    begin
        victim = oldest_reg;
        if (hit_reg)
        begin
            frame = tframe_reg;
        end
        else if (!fault)
        begin
            frame = p_frame_reg;
        end
        else if (!evict)
        begin
            frame = FW'(used_reg);
        end
        else
        begin
            frame = v_frame_reg;
        end
        empty_app = evict ? (used_reg <= UW'(1)) : (used_reg == '0);
    end

    // write ports: each memory takes at most two link writes; serialize
    // by using the commit cycle for one and folding where addresses allow
    // nx writes: prev(p).next = next(p) on touch; newest.next = p on append
    // pv writes: next(p).prev = prev(p) on touch; p.prev = newest on append
    // these two land at different cycles via a small second write slot
    logic          w2_reg;
    logic          w2_nx_we, w2_pv_we;
    logic [PW-1:0] w2_nx_a, w2_nx_d, w2_pv_a, w2_pv_d;
    logic          w2_nx_we_reg, w2_pv_we_reg;
    logic [PW-1:0] w2_nx_a_reg, w2_nx_d_reg, w2_pv_a_reg, w2_pv_d_reg;

    logic [PW-1:0] unl_p;
    logic [PW-1:0] unl_next, unl_prev;
    logic          do_unl, do_app;
    logic [PW-1:0] old_after, new_after;

    always_comb
    begin
        do_unl   = touch || evict;
        unl_p    = evict ? victim : page_reg;
        unl_next = evict ? v_next_reg : p_next_reg;
        unl_prev = p_prev_reg;
        do_app   = touch || fault;
        // unlink effect
        old_after = oldest_reg;
        new_after = newest_reg;
        nx_we = 1'b0; nx_waddr = '0; nx_wdata = '0;
        pv_we = 1'b0; pv_waddr = '0; pv_wdata = '0;
        w2_nx_we = 1'b0; w2_nx_a = '0; w2_nx_d = '0;
        w2_pv_we = 1'b0; w2_pv_a = '0; w2_pv_d = '0;
        if (cmd.commit && do_unl)
        begin
            if (unl_p == oldest_reg)
            begin
                old_after = unl_next;
            end
            else
            begin
                nx_we = 1'b1; nx_waddr = unl_prev; nx_wdata = unl_next;
            end
            if (unl_p == newest_reg)
            begin
                new_after = unl_prev;
            end
            else
            begin
                pv_we = 1'b1; pv_waddr = unl_next; pv_wdata = unl_prev;
            end
        end
        oldest_next = old_after;
        newest_next = new_after;
        if (cmd.commit && do_app)
        begin
            if (fault && empty_app)
            begin
                oldest_next = page_reg;
            end
            else
            begin
                w2_nx_we = 1'b1; w2_nx_a = new_after; w2_nx_d = page_reg;
                w2_pv_we = 1'b1; w2_pv_a = page_reg;  w2_pv_d = new_after;
            end
            newest_next = page_reg;
        end
        if (w2_reg)
        begin
            nx_we = w2_nx_we_reg; nx_waddr = w2_nx_a_reg; nx_wdata = w2_nx_d_reg;
            pv_we = w2_pv_we_reg; pv_waddr = w2_pv_a_reg; pv_wdata = w2_pv_d_reg;
        end
    end

    // victim prev was not read; for evict, victim is oldest so prev unused
    assign pf_we    = cmd.commit && fault;
    assign pf_waddr = page_reg;
    assign pf_wdata = frame;

    // valid bits: victim entries dropped, refilled entry and faulted page set
    always_comb
    begin
        tlb_valid_next = tlb_valid_reg;
        pvalid_next    = pvalid_reg;
        if (cmd.commit && !hit_reg)
        begin
            for (int k = 0; k < TLB_ENTRIES; k++)
            begin
                if (evict && tlb_valid_reg[k] && tlb_page_reg[k] == victim)
                begin
                    tlb_valid_next[k] = 1'b0;
                end
            end
            tlb_valid_next[tlb_ptr_reg] = 1'b1;
        end
        if (cmd.commit && evict)
        begin
            pvalid_next[victim] = 1'b0;
        end
        if (cmd.commit && fault)
        begin
            pvalid_next[page_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        w2_nx_we_reg <= w2_nx_we;
        w2_pv_we_reg <= w2_pv_we;
        w2_nx_a_reg  <= w2_nx_a;
        w2_nx_d_reg  <= w2_nx_d;
        w2_pv_a_reg  <= w2_pv_a;
        w2_pv_d_reg  <= w2_pv_d;
        if (cmd.commit)
        begin
            phys_out    <= AW'({frame, off_reg});
            hit_out     <= hit_reg;
            fault_out   <= fault;
            ev_out      <= evict;
            ev_page_out <= evict ? EW'(victim) : '0;
        end
        if (cmd.commit && !hit_reg)
        begin
            tlb_page_reg[tlb_ptr_reg]  <= page_reg;
            tlb_frame_reg[tlb_ptr_reg] <= frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tlb_valid_reg <= '0;
            tlb_ptr_reg   <= '0;
            pvalid_reg    <= '0;
            used_reg      <= '0;
            oldest_reg    <= '0;
            newest_reg    <= '0;
            w2_reg        <= 1'b0;
        end
        else
        begin
            w2_reg        <= cmd.commit;
            tlb_valid_reg <= tlb_valid_next;
            pvalid_reg    <= pvalid_next;
            if (cmd.commit)
            begin
                oldest_reg <= oldest_next;
                newest_reg <= newest_next;
                if (!hit_reg)
                begin
                    tlb_ptr_reg <= (tlb_ptr_reg == TW'(TLB_ENTRIES - 1)) ?
                                   '0 : tlb_ptr_reg + TW'(1);
                end
                if (fault && !evict)
                begin
                    used_reg <= used_reg + UW'(1);
                end
            end
        end
    end
endmodule

// ===== src/tlb_page_table_lru_translator.sv =====
// channel | dir | payload
// cfg     | in  | frame_count (9 bits)
// req     | in  | logical_address (16 bits)
// rsp     | out | physical_address, tlb_hit, page_fault, evicted, evicted_page
//
// one item at a time: capture with tlb search, page table read, victim
// read, link read (only when a page is evicted), commit. the result is
// registered at commit and the next item is taken when the result leaves.
// rst_n clears tlb and page valid bits, counters and the lru head/tail;
// the memories need no clearing. a held result blocks the next accept.
module tlb_page_table_lru_translator #(
    parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF,
    parameter int PAGE_COUNT  = tlbpt_pkg::PAGE_COUNT_DEF,
    parameter int FRAME_MAX   = tlbpt_pkg::FRAME_MAX_DEF,
    parameter int OFFSET_BITS = tlbpt_pkg::OFFSET_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    tlbpt_if.sink cfg,
    tlbpt_if.sink req,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output logic [tlbpt_pkg::ADDR_W-1:0]      physical_address,
    output logic                              tlb_hit,
    output logic                              page_fault,
    output logic                              evicted,
    output logic [tlbpt_pkg::EV_PAGE_W-1:0]   evicted_page
);
    tlbpt_pkg::tlbpt_cmd_t cmd;
    tlbpt_pkg::tlbpt_sts_t sts;
    logic                  req_ready;

    // config always accepted
    assign cfg.ready = 1'b1;
    assign req.ready = req_ready;

    tlbpt_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(req.valid), .in_ready(req_ready),
        .out_valid(rsp_valid), .out_ready(rsp_ready),
        .sts(sts), .cmd(cmd)
    );

    tlbpt_dp #(
        .TLB_ENTRIES(TLB_ENTRIES), .PAGE_COUNT(PAGE_COUNT),
        .FRAME_MAX(FRAME_MAX), .OFFSET_BITS(OFFSET_BITS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .addr_in(req.data[tlbpt_pkg::ADDR_W-1:0]),
        .cfg_we(cfg.valid),
        .cfg_data(cfg.data[tlbpt_pkg::CFG_W-1:0]),
        .phys_out(physical_address), .hit_out(tlb_hit),
        .fault_out(page_fault), .ev_out(evicted), .ev_page_out(evicted_page)
    );

`ifndef SYNTH
    // a hit is never a fault
    a_hit_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(tlb_hit && page_fault))
        else $error("hit and fault together");
    // eviction only on a fault
    a_ev_fault: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && evicted |-> page_fault)
        else $error("eviction without fault");
    // no accept while a result sits unread
    a_no_acc: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |-> !req_ready)
        else $error("accept while result pending");
`endif
endmodule

// ===== tb/tlbpt_xlat_checker.sv =====
`timescale 1ns / 100ps

module tlbpt_xlat_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [8:0]  cfg_data,
    input  logic        req_valid,
    input  logic        req_ready,
    input  logic [15:0] req_data,
    input  logic        rsp_valid,
    input  logic        rsp_ready,
    input  logic [15:0] physical_address,
    input  logic        tlb_hit,
    input  logic        page_fault,
    input  logic        evicted,
    input  logic [7:0]  evicted_page,
    output int          outstanding,
    output int          mismatches
);

    typedef struct packed {
        logic [15:0] phys;
        logic        hit;
        logic        fault;
        logic        ev;
        logic [7:0]  ev_page;
    } xlat_t;

    xlat_t      xlat_q[$];
    logic [8:0] frames_allowed;
    logic [7:0] tlb_pg [16];
    logic [7:0] tlb_fr [16];
    logic       tlb_ok [16];
    logic [3:0] tlb_ptr;
    logic [7:0] pt_frame [256];
    logic       pt_ok [256];
    logic [8:0] resident;
    logic [7:0] nxt [256];
    logic [7:0] prv [256];
    logic [7:0] oldest;
    logic [7:0] newest;

    task automatic unlink_page(input logic [7:0] p);
        if (p == oldest)
            oldest = nxt[p];
        else
            nxt[prv[p]] = nxt[p];
        if (p == newest)
            newest = prv[p];
        else
            prv[nxt[p]] = prv[p];
    endtask

    task automatic append_page(input logic [7:0] p, input logic empty);
        if (empty)
            oldest = p;
        else
        begin
            nxt[newest] = p;
            prv[p] = newest;
        end
        newest = p;
    endtask

    task automatic tlb_insert(input logic [7:0] p, input logic [7:0] f);
        tlb_pg[tlb_ptr] = p;
        tlb_fr[tlb_ptr] = f;
        tlb_ok[tlb_ptr] = 1'b1;
        tlb_ptr = tlb_ptr + 4'd1;
    endtask

    task automatic translate(input logic [15:0] addr, output xlat_t r);
        logic [7:0] page;
        logic [7:0] frame;
        logic [7:0] victim;
        logic [8:0] lim;
        logic       found;
        page = addr[15:8];
        frame = 8'd0;
        found = 1'b0;
        r = '0;
        lim = (frames_allowed == 9'd0) ? 9'd1 : frames_allowed;
        if (lim > 9'd256)
            lim = 9'd256;
        for (int k = 0; k < 16; k++)
            if (!found && tlb_ok[k] && tlb_pg[k] == page)
            begin
                found = 1'b1;
                frame = tlb_fr[k];
            end
        if (found || pt_ok[page])
        begin
            if (!found)
                frame = pt_frame[page];
            if (page != newest)
            begin
                unlink_page(page);
                append_page(page, 1'b0);
            end
            if (!found)
                tlb_insert(page, frame);
        end
        else
        begin
            r.fault = 1'b1;
            if (resident < lim)
            begin
                frame = resident[7:0];
                append_page(page, resident == 9'd0);
                resident = resident + 9'd1;
            end
            else
            begin
                victim = oldest;
                r.ev = 1'b1;
                r.ev_page = victim;
                frame = pt_frame[victim];
                pt_ok[victim] = 1'b0;
                for (int k = 0; k < 16; k++)
                    if (tlb_ok[k] && tlb_pg[k] == victim)
                        tlb_ok[k] = 1'b0;
                unlink_page(victim);
                append_page(page, resident <= 9'd1);
            end
            pt_frame[page] = frame;
            pt_ok[page] = 1'b1;
            tlb_insert(page, frame);
        end
        r.hit = found;
        r.phys = {frame, addr[7:0]};
    endtask

    assign outstanding = xlat_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        xlat_t e;
        xlat_t got;
        if (!rst_n)
        begin
            xlat_q.delete();
            mismatches <= 0;
            frames_allowed = 9'd128;
            tlb_ptr = '0;
            resident = '0;
            oldest = '0;
            newest = '0;
            for (int k = 0; k < 16; k++)
            begin
                tlb_pg[k] = '0;
                tlb_fr[k] = '0;
                tlb_ok[k] = 1'b0;
            end
            for (int k = 0; k < 256; k++)
            begin
                pt_frame[k] = '0;
                pt_ok[k] = 1'b0;
                nxt[k] = '0;
                prv[k] = '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                frames_allowed = cfg_data;
            if (req_valid && req_ready)
            begin
                translate(req_data, e);
                xlat_q.push_back(e);
            end
            if (rsp_valid && rsp_ready)
            begin
                got = '{physical_address, tlb_hit, page_fault, evicted, evicted_page};
                if (xlat_q.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, got);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    e = xlat_q.pop_front();
                    if (got !== e)
                    begin
                        $display("%0t: mismatch exp pa=%h hit=%b flt=%b ev=%b evp=%h",
                                 $time, e.phys, e.hit, e.fault, e.ev, e.ev_page);
                        $display("%0t:          act pa=%h hit=%b flt=%b ev=%b evp=%h",
                                 $time, got.phys, got.hit, got.fault, got.ev, got.ev_page);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/tlb_page_table_lru_translator_tb.sv =====
`timescale 1ns / 100ps

module tlb_page_table_lru_translator_tb;

    logic        clk;
    logic        rst_n;
    logic        rsp_ready;
    logic [15:0] physical_address;
    logic        tlb_hit;
    logic        page_fault;
    logic        evicted;
    logic [7:0]  evicted_page;
    logic        rsp_valid;
    int          outstanding;
    int          mismatches;
    int          cycles;
    int          sent;
    // no random gaps on either side while set
    logic        steady;
    // the receiver's long hold-off has been done
    logic        hold_done;

    tlbpt_if #(.W(tlbpt_pkg::CFG_W))  cfg_ch ();
    tlbpt_if #(.W(tlbpt_pkg::ADDR_W)) req_ch ();

    tlb_page_table_lru_translator i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_ch),
        .req              (req_ch),
        .rsp_valid        (rsp_valid),
        .rsp_ready        (rsp_ready),
        .physical_address (physical_address),
        .tlb_hit          (tlb_hit),
        .page_fault       (page_fault),
        .evicted          (evicted),
        .evicted_page     (evicted_page)
    );

    tlbpt_xlat_checker i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_ch.valid),
        .cfg_ready        (cfg_ch.ready),
        .cfg_data         (cfg_ch.data),
        .req_valid        (req_ch.valid),
        .req_ready        (req_ch.ready),
        .req_data         (req_ch.data),
        .rsp_valid        (rsp_valid),
        .rsp_ready        (rsp_ready),
        .physical_address (physical_address),
        .tlb_hit          (tlb_hit),
        .page_fault       (page_fault),
        .evicted          (evicted),
        .evicted_page     (evicted_page),
        .outstanding      (outstanding),
        .mismatches       (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog, far above the slowest legal run
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 200000)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus one long hold while items keep coming
    initial
    begin
        rsp_ready = 1'b0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            // a little way into the third random phase
            if (!hold_done && sent >= 415)
            begin
                rsp_ready = 1'b0;
                repeat (120) @(negedge clk);
                hold_done = 1'b1;
            end
            rsp_ready = steady || ($urandom_range(99) >= 15);
        end
    end

    // one item on the request channel; valid stays up until the next gap
    task automatic send_addr(input logic [15:0] a);
        if (!steady && $urandom_range(99) < 15)
        begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        req_ch.valid = 1'b1;
        req_ch.data = a;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
        sent++;
    endtask

    // frame_count write, only with nothing in flight
    task automatic set_frames(input logic [8:0] v);
        req_ch.valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.data = v;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // mostly a small working set so hits and lru order matter
    function automatic logic [15:0] pick_addr(input int spread);
        logic [7:0] pg;
        int         r;
        r = $urandom_range(99);
        if (r < 10)
            return 16'($urandom);
        pg = 8'($urandom_range(spread - 1));
        if (r < 20)
            pg = ~pg;
        return {pg, 8'($urandom)};
    endfunction

    initial
    begin
        logic [8:0] frame_settings [8];
        int         spreads [8];
        frame_settings = '{9'd1, 9'd0, 9'd256, 9'd511, 9'd3, 9'd16, 9'd200, 9'd2};
        spreads        = '{4, 3, 256, 40, 6, 24, 220, 5};
        steady = 1'b0;
        sent = 0;
        rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: field extremes, hits, reloads from the page table
        send_addr(16'h0000);
        send_addr(16'h00FF);
        send_addr(16'hFF00);
        send_addr(16'hFFFF);
        send_addr(16'h0000);
        send_addr(16'hA55A);
        send_addr(16'h5AA5);
        for (int k = 1; k <= 17; k++)
            send_addr({8'(k), 8'(k * 13)});
        // page 1 fell out of the tlb; comes back from the page table
        send_addr(16'h0177);

        // frame_count 1: every new page evicts the oldest resident one
        set_frames(9'd1);
        send_addr(16'h1234);
        send_addr(16'h5678);
        send_addr(16'h5601);
        send_addr(16'h1234);

        // random phases over settings including the extremes
        for (int ph = 0; ph < 8; ph++)
        begin
            set_frames(frame_settings[ph]);
            for (int n = 0; n < 183; n++)
            begin
                steady = (ph == 3);
                send_addr(pick_addr(spreads[ph]));
            end
            steady = 1'b0;
        end
        // lowered below frames in use: all later faults evict
        set_frames(9'd2);
        for (int n = 0; n < 60; n++)
            send_addr(pick_addr(8));
        req_ch.valid = 1'b0;

        while (outstanding != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
